// ===== src/dlt_pkg.sv =====
// Package for the DVFS limiter: shared widths, codes, configuration and result types.
`default_nettype none

package dlt_pkg;

    // Field widths.
    localparam int FREQ_W    = 22;
    localparam int MS_W      = 14;
    localparam int FINGERS_W = 4;
    localparam int TALLY_W   = 4;
    localparam int TYPE_W    = 3;
    localparam int LEVEL_W   = 2;
    localparam int CFG_IDX_W = 4;

    // Parameter defaults.
    localparam int KICK_HOLD_MS_DEF  = 0;
    localparam int BOOST_TOUCHES_DEF = 5;

    localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] R_ON_CEIL    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] R_ON_FLOOR   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] R_OFF_CEIL   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] R_OFF_FLOOR  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] R_KICK_FLOOR = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] R_BLO_FLOOR  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] R_BHI_FLOOR  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] R_HOLD       = CFG_IDX_W'(7);

    // Request codes.
    typedef enum logic [TYPE_W-1:0] {
        REQ_CLAMP      = 3'd0,
        REQ_SCREEN_OFF = 3'd1,
        REQ_SCREEN_ON  = 3'd2,
        REQ_TOUCH      = 3'd3,
        REQ_TICK       = 3'd4
    } req_type_t;

    // Touch boost levels.
    typedef enum logic [LEVEL_W-1:0] {
        BOOST_NONE = 2'd0,
        BOOST_LOW  = 2'd1,
        BOOST_HIGH = 2'd2
    } boost_t;

    // Contents of the configuration registers.
    typedef struct packed {
        logic [FREQ_W-1:0] on_ceiling;
        logic [FREQ_W-1:0] on_floor;
        logic [FREQ_W-1:0] off_ceiling;
        logic [FREQ_W-1:0] off_floor;
        logic [FREQ_W-1:0] kick_floor;
        logic [FREQ_W-1:0] boost_low_floor;
        logic [FREQ_W-1:0] boost_high_floor;
        logic [MS_W-1:0]   boost_hold_ms;
    } cfg_t;

    // One result transaction.
    typedef struct packed {
        logic [FREQ_W-1:0]  clamped_freq;
        logic [FREQ_W-1:0]  floor_now;
        logic [FREQ_W-1:0]  ceiling_now;
        logic [LEVEL_W-1:0] boost_level_now;
        logic               kick_now;
    } result_t;

endpackage

`default_nettype wire

// ===== src/dlt_cfg_regs.sv =====
// Configuration register bank of the DVFS limiter.
`default_nettype none

module dlt_cfg_regs
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [dlt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dlt_pkg::FREQ_W-1:0]   cfg_data,
    output      dlt_pkg::cfg_t                cfg
);
    import dlt_pkg::*;

    cfg_t cfg_reg;

    // Register writes; indexes beyond the bank are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_ceiling       <= FREQ_MAX;
            cfg_reg.on_floor         <= '0;
            cfg_reg.off_ceiling      <= FREQ_MAX;
            cfg_reg.off_floor        <= '0;
            cfg_reg.kick_floor       <= '0;
            cfg_reg.boost_low_floor  <= '0;
            cfg_reg.boost_high_floor <= '0;
            cfg_reg.boost_hold_ms    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                R_ON_CEIL:    cfg_reg.on_ceiling       <= cfg_data;
                R_ON_FLOOR:   cfg_reg.on_floor         <= cfg_data;
                R_OFF_CEIL:   cfg_reg.off_ceiling      <= cfg_data;
                R_OFF_FLOOR:  cfg_reg.off_floor        <= cfg_data;
                R_KICK_FLOOR: cfg_reg.kick_floor       <= cfg_data;
                R_BLO_FLOOR:  cfg_reg.boost_low_floor  <= cfg_data;
                R_BHI_FLOOR:  cfg_reg.boost_high_floor <= cfg_data;
                R_HOLD:       cfg_reg.boost_hold_ms    <= cfg_data[MS_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/dlt_core.sv =====
// Limiter state and the single-pass update that turns one request into one result.
`default_nettype none

module dlt_core
#(
    parameter int KICK_HOLD_MS  = dlt_pkg::KICK_HOLD_MS_DEF,
    parameter int BOOST_TOUCHES = dlt_pkg::BOOST_TOUCHES_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dlt_pkg::cfg_t                  cfg,
    input  wire logic                           step,
    input  wire logic [dlt_pkg::TYPE_W-1:0]     req_type,
    input  wire logic [dlt_pkg::FREQ_W-1:0]     req_freq,
    input  wire logic [dlt_pkg::FINGERS_W-1:0]  fingers,
    output      dlt_pkg::result_t               result
);
    import dlt_pkg::*;

    localparam logic [MS_W-1:0]    KICK_LOAD   = MS_W'(KICK_HOLD_MS);
    localparam logic [TALLY_W-1:0] TOUCH_LIMIT = TALLY_W'(BOOST_TOUCHES);

    logic                 screen_reg,     screen_next;
    logic                 kick_reg,       kick_next;
    logic [MS_W-1:0]      kick_left_reg,  kick_left_next;
    boost_t               boost_reg,      boost_next;
    logic [MS_W-1:0]      boost_left_reg, boost_left_next;
    logic [TALLY_W-1:0]   tally_reg,      tally_next;
    logic [FINGERS_W-1:0] last_fing_reg,  last_fing_next;

    logic [FREQ_W-1:0] pre_floor;
    logic [FREQ_W-1:0] pre_ceil;
    logic [FREQ_W-1:0] post_floor;
    logic [FREQ_W-1:0] post_ceil;
    logic [FREQ_W-1:0] capped;

    // Floor selection from screen, kick and boost state.
    function automatic logic [FREQ_W-1:0] pick_floor(input cfg_t c, input logic scr,
                                                     input logic kick, input boost_t lvl);
        logic [FREQ_W-1:0] f;
        if (!scr)
            f = c.off_floor;
        else if (kick)
            f = c.kick_floor;
        else if (lvl == BOOST_LOW)
            f = c.boost_low_floor;
        else if (lvl == BOOST_NONE)
            f = c.on_floor;
        else
            f = c.boost_high_floor;
        return f;
    endfunction

    // State registers, advanced once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reg     <= 1'b1;
            kick_reg       <= 1'b0;
            kick_left_reg  <= '0;
            boost_reg      <= BOOST_NONE;
            boost_left_reg <= '0;
            tally_reg      <= '0;
            last_fing_reg  <= '0;
        end
        else if (step)
        begin
            screen_reg     <= screen_next;
            kick_reg       <= kick_next;
            kick_left_reg  <= kick_left_next;
            boost_reg      <= boost_next;
            boost_left_reg <= boost_left_next;
            tally_reg      <= tally_next;
            last_fing_reg  <= last_fing_next;
        end
    end

    // Next state for the request in hand.
    always_comb
    begin
        screen_next     = screen_reg;
        kick_next       = kick_reg;
        kick_left_next  = kick_left_reg;
        boost_next      = boost_reg;
        boost_left_next = boost_left_reg;
        tally_next      = tally_reg;
        last_fing_next  = last_fing_reg;
        case (req_type)
            REQ_SCREEN_OFF:
            begin
                screen_next = 1'b0;
            end
            REQ_SCREEN_ON:
            begin
                screen_next = 1'b1;
                if (KICK_LOAD == '0)
                    kick_next = 1'b0;
                else
                begin
                    kick_next      = 1'b1;
                    kick_left_next = KICK_LOAD;
                end
            end
            REQ_TOUCH:
            begin
                // Touch boost is disabled entirely while the hold time is zero.
                if (cfg.boost_hold_ms != '0)
                begin
                    if (fingers != '0)
                    begin
                        if (boost_reg == BOOST_NONE)
                        begin
                            boost_next = BOOST_LOW;
                            tally_next = TALLY_W'(1);
                        end
                        else if (boost_reg == BOOST_LOW)
                        begin
                            if (tally_reg < TOUCH_LIMIT)
                            begin
                                if (last_fing_reg < fingers)
                                    tally_next = tally_reg + TALLY_W'(1);
                            end
                            else
                                boost_next = BOOST_HIGH;
                        end
                        boost_left_next = cfg.boost_hold_ms;
                    end
                    last_fing_next = fingers;
                end
            end
            REQ_TICK:
            begin
                if (kick_reg)
                begin
                    if (kick_left_reg > MS_W'(1))
                        kick_left_next = kick_left_reg - MS_W'(1);
                    else
                    begin
                        kick_left_next = '0;
                        kick_next      = 1'b0;
                    end
                end
                if (boost_reg != BOOST_NONE)
                begin
                    if (boost_left_reg > MS_W'(1))
                        boost_left_next = boost_left_reg - MS_W'(1);
                    else
                    begin
                        boost_left_next = '0;
                        boost_next      = BOOST_NONE;
                        tally_next      = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Limits before the request (for the clamp) and after it (for the report).
    always_comb
    begin
        pre_floor  = pick_floor(cfg, screen_reg, kick_reg, boost_reg);
        pre_ceil   = screen_reg ? cfg.on_ceiling : cfg.off_ceiling;
        post_floor = pick_floor(cfg, screen_next, kick_next, boost_next);
        post_ceil  = screen_next ? cfg.on_ceiling : cfg.off_ceiling;
        capped     = (req_freq < pre_ceil) ? req_freq : pre_ceil;
    end

    // Result assembly; the floor wins over the ceiling.
    always_comb
    begin
        result.clamped_freq    = '0;
        if (req_type == REQ_CLAMP)
            result.clamped_freq = (capped > pre_floor) ? capped : pre_floor;
        result.floor_now       = post_floor;
        result.ceiling_now     = post_ceil;
        result.boost_level_now = boost_next;
        result.kick_now        = kick_next;
    end

endmodule

`default_nettype wire

// ===== src/dvfs_limit_touch_boost.sv =====
// Top level of the DVFS frequency limiter with wake-up kick and touch boost.
//
// Usage: requests enter on the in_valid/in_ready channel (req_type, req_freq,
// fingers) and each request yields exactly one result transaction on the
// out_valid/out_ready channel. A transaction is captured in an input register,
// its state update and limit selection are done by one pass of combinational
// logic, and the result lands in an output register.
// The result is loaded into the output register when the held transaction
// advances, which it does unless the output register holds an untaken result.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the single update pass between the input and output registers.
// A stalled receiver holds the output register; the input register still
// accepts one more transaction, after which in_ready drops until the output
// frees up. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
// the next clock edge and should be made while no transaction is in flight;
// indexes beyond the register bank are ignored.
// Reset: screen on, no kick, no boost, ceilings at the top of the range,
// floors at zero, boost hold time zero, both pipeline registers empty.
`default_nettype none

module dvfs_limit_touch_boost
#(
    parameter int KICK_HOLD_MS  = dlt_pkg::KICK_HOLD_MS_DEF,
    parameter int BOOST_TOUCHES = dlt_pkg::BOOST_TOUCHES_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic [dlt_pkg::TYPE_W-1:0]     req_type,
    input  wire logic [dlt_pkg::FREQ_W-1:0]     req_freq,
    input  wire logic [dlt_pkg::FINGERS_W-1:0]  fingers,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic [dlt_pkg::FREQ_W-1:0]     clamped_freq,
    output      logic [dlt_pkg::FREQ_W-1:0]     floor_now,
    output      logic [dlt_pkg::FREQ_W-1:0]     ceiling_now,
    output      logic [dlt_pkg::LEVEL_W-1:0]    boost_level_now,
    output      logic                           kick_now,
    input  wire logic                           cfg_we,
    input  wire logic [dlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dlt_pkg::FREQ_W-1:0]     cfg_data
);
    import dlt_pkg::*;

    cfg_t                 cfg;
    result_t              core_result;
    result_t              res_reg;
    logic                 s1_valid_reg;
    logic                 out_valid_reg;
    logic [TYPE_W-1:0]    type_reg;
    logic [FREQ_W-1:0]    freq_reg;
    logic [FINGERS_W-1:0] fing_reg;
    logic                 advance;

    // The held transaction moves on whenever the output register is free or emptying.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    dlt_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlt_core
    #(
        .KICK_HOLD_MS  (KICK_HOLD_MS),
        .BOOST_TOUCHES (BOOST_TOUCHES)
    )
    u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .step     (advance),
        .req_type (type_reg),
        .req_freq (freq_reg),
        .fingers  (fing_reg),
        .result   (core_result)
    );

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            type_reg <= req_type;
            freq_reg <= req_freq;
            fing_reg <= fingers;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= core_result;
    end

    assign out_valid       = out_valid_reg;
    assign clamped_freq    = res_reg.clamped_freq;
    assign floor_now       = res_reg.floor_now;
    assign ceiling_now     = res_reg.ceiling_now;
    assign boost_level_now = res_reg.boost_level_now;
    assign kick_now        = res_reg.kick_now;

endmodule

`default_nettype wire
